// File: hw/rtl/mrtx_pkg.sv
// shared types, field widths and codes for the message ring transmit flow control core
package mrtx_pkg;

  localparam int SLOT_W     = 4;
  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 24;
  localparam int INL_W      = 10;
  localparam int BC_W       = 5;
  localparam int CNT_W      = 5;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_SLOTS_DEFAULT = 16;

  localparam logic [CNT_W-1:0] PENDING_MAX = 5'd31;

  localparam logic [BC_W-1:0]  BC_RESET      = 5'd16;
  localparam logic [LEN_W-1:0] MAX_MSG_RESET = 24'd4096;
  localparam logic [INL_W-1:0] MAX_INL_RESET = 10'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INLINE   = 2'd2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEND       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETION = 2'd2;

  typedef enum logic [2:0] {
    ST_OK                = 3'd0,
    ST_BUSY              = 3'd1,
    ST_FREED_MISMATCH    = 3'd2,
    ST_BAD_SEND          = 3'd3,
    ST_NEED_COMPLETION   = 3'd4,
    ST_STILL_OWNED       = 3'd5,
    ST_COMPLETION_FAILED = 3'd6
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot_index;
    logic [SEQ_W-1:0]  freed_sample;
    logic [LEN_W-1:0]  msg_bytes;
    logic              completion_ok;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] granted_slot;
    logic [SEQ_W-1:0]  seq_stamp;
    logic              post_data_first;
    logic              data_inline;
    logic              header_signalled;
    logic [CNT_W-1:0]  outstanding_count;
  } result_t;

  typedef struct packed {
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] expected_freed_seq;
    logic [SEQ_W-1:0] not_freed_seq;
    logic             awaiting_free;
    logic             app_owned;
  } slot_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] pacing;
    logic [CNT_W-1:0] pending;
  } counts_t;

  typedef struct packed {
    logic        slot_we;
    slot_entry_t entry;
    logic        ptr_adv;
    counts_t     counts;
  } ring_upd_t;

endpackage

// File: hw/rtl/mrtx_ring_state.sv
// slot table, ring pointer and pacing and completion counters
module mrtx_ring_state #(
  parameter int MAX_SLOTS = mrtx_pkg::MAX_SLOTS_DEFAULT,
  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       init,
  input  logic                       apply,
  input  logic [mrtx_pkg::BC_W-1:0]  n,
  input  logic [PW-1:0]              rd_addr,
  input  mrtx_pkg::ring_upd_t        upd,
  output mrtx_pkg::slot_entry_t      entry,
  output logic [PW-1:0]              ptr,
  output mrtx_pkg::counts_t          counts
);
  import mrtx_pkg::*;

  localparam int CW = (PW + 1 > BC_W) ? PW + 1 : BC_W;

  slot_entry_t   ring [MAX_SLOTS];
  logic [CW-1:0] ptr_inc;
  logic [PW-1:0] ptr_next;

  assign entry = ring[rd_addr];

  // wrap at the number of slots in use
  always_comb begin
    ptr_inc  = CW'(ptr) + CW'(1);
    ptr_next = (ptr_inc == CW'(n)) ? '0 : ptr_inc[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (init) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        ring[i].next_seq           <= SEQ_W'(i + 1);
        ring[i].expected_freed_seq <= SEQ_W'(i + 1);
        ring[i].not_freed_seq      <= '0;
        ring[i].awaiting_free      <= 1'b0;
        ring[i].app_owned          <= 1'b0;
      end
      ptr    <= '0;
      counts <= '0;
    end else if (apply) begin
      if (upd.slot_we) begin
        ring[rd_addr] <= upd.entry;
      end
      if (upd.ptr_adv) begin
        ptr <= ptr_next;
      end
      counts <= upd.counts;
    end
  end

endmodule

// File: hw/rtl/mrtx_decide.sv
// per-word decision logic: grant, send stamping, pacing and completion accounting
module mrtx_decide #(
  parameter int MAX_SLOTS = mrtx_pkg::MAX_SLOTS_DEFAULT,
  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  mrtx_pkg::item_t               item,
  input  logic [PW-1:0]                 ptr,
  input  mrtx_pkg::slot_entry_t         entry,
  input  mrtx_pkg::counts_t             counts,
  input  logic [mrtx_pkg::BC_W-1:0]     n,
  input  logic [mrtx_pkg::LEN_W-1:0]    max_message_bytes,
  input  logic [mrtx_pkg::INL_W-1:0]    max_inline_bytes,
  output logic [PW-1:0]                 rd_addr,
  output mrtx_pkg::result_t             res,
  output mrtx_pkg::ring_upd_t           upd
);
  import mrtx_pkg::*;

  logic             bad_send;
  logic [CNT_W-1:0] pacing_base;

  assign rd_addr = (item.func == FUNC_ACQUIRE) ? ptr : PW'(item.slot_index);

  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    upd         = '0;
    upd.entry   = entry;
    upd.counts  = counts;
    bad_send    = ({1'b0, item.slot_index} >= n) || !entry.app_owned ||
                  (item.msg_bytes > max_message_bytes);
    pacing_base = (counts.pacing >= n) ? '0 : counts.pacing;

    case (item.func)
      FUNC_ACQUIRE: begin
        res.granted_slot = SLOT_W'(ptr);
        if (entry.app_owned) begin
          res.status = ST_STILL_OWNED;
        end else if (!entry.awaiting_free) begin
          upd.slot_we = 1'b1;
        end else if (item.freed_sample == entry.expected_freed_seq) begin
          upd.entry.not_freed_seq      = entry.expected_freed_seq;
          upd.entry.expected_freed_seq = entry.next_seq;
          upd.entry.awaiting_free      = 1'b0;
          upd.slot_we                  = 1'b1;
        end else if (item.freed_sample == entry.not_freed_seq) begin
          res.status = ST_BUSY;
        end else begin
          res.status = ST_FREED_MISMATCH;
        end
        if (upd.slot_we) begin
          upd.entry.app_owned = 1'b1;
          upd.ptr_adv         = 1'b1;
        end
      end
      FUNC_SEND: begin
        res.granted_slot = item.slot_index;
        if (bad_send) begin
          res.status = ST_BAD_SEND;
        end else if ((counts.pacing >= n) && (counts.pending != '0)) begin
          res.status = ST_NEED_COMPLETION;
        end else begin
          upd.slot_we             = 1'b1;
          upd.entry.app_owned     = 1'b0;
          upd.entry.awaiting_free = 1'b1;
          upd.entry.next_seq      = entry.next_seq + SEQ_W'(n);
          res.seq_stamp           = entry.next_seq;
          if (pacing_base == '0) begin
            res.header_signalled = 1'b1;
            if (counts.pending != PENDING_MAX) begin
              upd.counts.pending = counts.pending + CNT_W'(1);
            end
          end
          upd.counts.pacing = pacing_base + CNT_W'(1);
          if (item.msg_bytes != '0) begin
            res.post_data_first = 1'b1;
            res.data_inline     = (item.msg_bytes <= LEN_W'(max_inline_bytes));
          end
        end
      end
      FUNC_COMPLETION: begin
        if (!item.completion_ok) begin
          res.status = ST_COMPLETION_FAILED;
        end else if (counts.pending != '0) begin
          upd.counts.pending = counts.pending - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    res.outstanding_count = upd.counts.pending;
  end

endmodule

// File: hw/rtl/message_ring_tx_flow_control_core.sv
// top level of the message ring transmit flow control core
// an accepted word passes the input register, then the result register under done
// throughput: one word per cycle while busy is low; the next word sees each update
// the receiver cannot stall: each result is shown for exactly one cycle under done
// reset (synchronous, active high) restores config, control registers and slot table;
// busy stays high during reset and falls at the first clock edge after it
module message_ring_tx_flow_control_core #(
  parameter int MAX_SLOTS = mrtx_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mrtx_pkg::item_t                   item,
  output logic                              done,
  output mrtx_pkg::result_t                 result,
  input  logic                              cfg_write,
  input  logic [mrtx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrtx_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mrtx_pkg::*;

  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // configuration registers
  logic [BC_W-1:0]  buffer_count;
  logic [LEN_W-1:0] max_message_bytes;
  logic [INL_W-1:0] max_inline_bytes;
  logic [BC_W-1:0]  n;

  // input register
  logic  s1_valid;
  item_t s1_item;

  // ring state and decision
  logic          ring_init;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] ptr;
  slot_entry_t   entry;
  counts_t       counts;
  ring_upd_t     upd;
  result_t       res;

  // slots in use: zero acts as one, anything above the table depth is clamped
  always_comb begin
    if (buffer_count == '0) begin
      n = BC_W'(1);
    end else if (int'(buffer_count) > MAX_SLOTS) begin
      n = BC_W'(MAX_SLOTS);
    end else begin
      n = buffer_count;
    end
  end

  // a buffer_count write restarts the whole ring
  assign ring_init = rst || (cfg_write && (cfg_index == CFG_BUFFER_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count      <= BC_RESET;
      max_message_bytes <= MAX_MSG_RESET;
      max_inline_bytes  <= MAX_INL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BUFFER_COUNT: buffer_count      <= cfg_data[BC_W-1:0];
        CFG_MAX_MESSAGE:  max_message_bytes <= cfg_data[LEN_W-1:0];
        CFG_MAX_INLINE:   max_inline_bytes  <= cfg_data[INL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register, result register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= start && !busy;
      done     <= s1_valid;
    end
    if (start && !busy) begin
      s1_item <= item;
    end
    if (s1_valid) begin
      result <= res;
    end
  end

  mrtx_ring_state #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_state (
    .clk     (clk),
    .init    (ring_init),
    .apply   (s1_valid),
    .n       (n),
    .rd_addr (rd_addr),
    .upd     (upd),
    .entry   (entry),
    .ptr     (ptr),
    .counts  (counts)
  );

  mrtx_decide #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_decide (
    .item              (s1_item),
    .ptr               (ptr),
    .entry             (entry),
    .counts            (counts),
    .n                 (n),
    .max_message_bytes (max_message_bytes),
    .max_inline_bytes  (max_inline_bytes),
    .rd_addr           (rd_addr),
    .res               (res),
    .upd               (upd)
  );

  // every accepted word yields a result under done
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted word produced no result");

  // a signalled header always leaves at least one completion outstanding
  a_signalled_pending: assert property (@(posedge clk) disable iff (rst)
    (done && result.header_signalled) |->
      (result.status == ST_OK && result.outstanding_count != '0))
    else $error("signalled header without outstanding completion");

  // inline data only with a data request
  a_inline_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.data_inline) |-> result.post_data_first)
    else $error("inline flag without data request");

  // refused words never stamp a header
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.seq_stamp == '0 && !result.post_data_first &&
       !result.header_signalled))
    else $error("refused word carries send fields");

endmodule

// File: tb/ring_flow_checker.sv
// checker for the message ring transmit core: predicts every word and compares the results
module ring_flow_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  mrtx_pkg::item_t                      item,
  input  logic                                 done,
  input  mrtx_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [mrtx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrtx_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   waiting,
  output logic [mrtx_pkg::BC_W-1:0]            slots_view,
  output logic [mrtx_pkg::SLOT_W-1:0]          ring_view,
  output logic [15:0]                          owned_view,
  output logic [15:0]                          awaiting_view,
  output logic [15:0][mrtx_pkg::SEQ_W-1:0]     freed_view,
  output logic [15:0][mrtx_pkg::SEQ_W-1:0]     unfreed_view
);
  import mrtx_pkg::*;

  localparam int NS = MAX_SLOTS_DEFAULT;

  logic [BC_W-1:0]   buf_count;
  logic [LEN_W-1:0]  max_msg;
  logic [INL_W-1:0]  max_inl;

  logic [SEQ_W-1:0]  next_seq   [NS];
  logic [SEQ_W-1:0]  exp_freed  [NS];
  logic [SEQ_W-1:0]  not_freed  [NS];
  logic              awaiting   [NS];
  logic              owned      [NS];
  logic [SLOT_W-1:0] ring_ptr;
  logic [CNT_W-1:0]  pacing;
  logic [CNT_W-1:0]  pending;

  result_t predicted_results[$];
  result_t want;

  function automatic logic [BC_W-1:0] active_slots();
    if (buf_count == 0) return BC_W'(1);
    if (buf_count > NS) return BC_W'(NS);
    return buf_count;
  endfunction

  task automatic init_ring();
    for (int i = 0; i < NS; i++) begin
      next_seq[i]  = SEQ_W'(i + 1);
      exp_freed[i] = SEQ_W'(i + 1);
      not_freed[i] = '0;
      awaiting[i]  = 1'b0;
      owned[i]     = 1'b0;
    end
    ring_ptr = '0;
    pacing   = '0;
    pending  = '0;
  endtask

  // apply one word to the ring state and return the result it causes
  function automatic result_t advance_ring(item_t w);
    result_t         r;
    logic [BC_W-1:0] n;
    int              s;
    r = '0;
    r.status = ST_OK;
    n = active_slots();
    case (w.func)
      FUNC_ACQUIRE: begin
        s = int'(ring_ptr) % int'(n);
        r.granted_slot = SLOT_W'(s);
        if (owned[s]) begin
          r.status = ST_STILL_OWNED;
        end else if (!awaiting[s] || w.freed_sample == exp_freed[s]) begin
          if (awaiting[s]) begin
            not_freed[s] = exp_freed[s];
            exp_freed[s] = next_seq[s];
            awaiting[s]  = 1'b0;
          end
          owned[s] = 1'b1;
          ring_ptr = SLOT_W'((s + 1) % int'(n));
        end else if (w.freed_sample == not_freed[s]) begin
          r.status = ST_BUSY;
        end else begin
          r.status = ST_FREED_MISMATCH;
        end
      end
      FUNC_SEND: begin
        s = int'(w.slot_index);
        r.granted_slot = w.slot_index;
        if (s >= int'(n) || !owned[s] || w.msg_bytes > max_msg) begin
          r.status = ST_BAD_SEND;
        end else if (pacing >= n && pending != 0) begin
          r.status = ST_NEED_COMPLETION;
        end else begin
          if (pacing >= n) pacing = '0;
          owned[s] = 1'b0;
          r.seq_stamp = next_seq[s];
          if (pacing == 0) begin
            r.header_signalled = 1'b1;
            if (pending < PENDING_MAX) pending = pending + CNT_W'(1);
          end
          pacing = pacing + CNT_W'(1);
          if (w.msg_bytes != 0) begin
            r.post_data_first = 1'b1;
            r.data_inline = (w.msg_bytes <= LEN_W'(max_inl));
          end
          awaiting[s] = 1'b1;
          next_seq[s] = next_seq[s] + SEQ_W'(n);
        end
      end
      FUNC_COMPLETION: begin
        if (!w.completion_ok) r.status = ST_COMPLETION_FAILED;
        else if (pending != 0) pending = pending - CNT_W'(1);
      end
      default: ;
    endcase
    r.outstanding_count = pending;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      buf_count = BC_RESET;
      max_msg   = MAX_MSG_RESET;
      max_inl   = MAX_INL_RESET;
      init_ring();
      predicted_results.delete();
    end else begin
      if (done) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t: unexpected result word, expected none, got %h", $time, result);
        end else begin
          want = predicted_results.pop_front();
          if (want !== result) begin
            fail_count++;
            // keep the log readable when everything goes wrong
            if (fail_count <= 50)
              $display("%0t: mismatch, expected st %0d slot %0d seq %h pdf %b inl %b sig %b ",
                       $time, want.status, want.granted_slot, want.seq_stamp,
                       want.post_data_first, want.data_inline, want.header_signalled,
                       "out %0d, actual st %0d slot %0d seq %h pdf %b inl %b sig %b out %0d",
                       want.outstanding_count, result.status, result.granted_slot,
                       result.seq_stamp, result.post_data_first, result.data_inline,
                       result.header_signalled, result.outstanding_count);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_BUFFER_COUNT: begin
            buf_count = cfg_data[BC_W-1:0];
            init_ring();
          end
          CFG_MAX_MESSAGE: max_msg = cfg_data[LEN_W-1:0];
          CFG_MAX_INLINE:  max_inl = cfg_data[INL_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) predicted_results.push_back(advance_ring(item));
    end
    waiting    = predicted_results.size();
    slots_view = active_slots();
    ring_view  = ring_ptr;
    for (int i = 0; i < NS; i++) begin
      owned_view[i]    = owned[i];
      awaiting_view[i] = awaiting[i];
      freed_view[i]    = exp_freed[i];
      unfreed_view[i]  = not_freed[i];
    end
  end

endmodule

// File: tb/message_ring_tx_flow_control_core_tb.sv
// testbench top for the message ring transmit core: stimulus, register phases and verdict
module message_ring_tx_flow_control_core_tb;
  import mrtx_pkg::*;

  // func value with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  logic                  done;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    fail_count;
  int                    waiting;
  logic [BC_W-1:0]       slots_view;
  logic [SLOT_W-1:0]     ring_view;
  logic [15:0]           owned_view;
  logic [15:0]           awaiting_view;
  logic [15:0][SEQ_W-1:0] freed_view;
  logic [15:0][SEQ_W-1:0] unfreed_view;

  // limits the stimulus side believes are programmed, used to shape lengths
  logic [LEN_W-1:0]      cur_max_msg;
  logic [INL_W-1:0]      cur_max_inl;
  int                    phase_words;
  item_t                 plan[$];

  message_ring_tx_flow_control_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ring_flow_checker chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .done          (done),
    .result        (result),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .waiting       (waiting),
    .slots_view    (slots_view),
    .ring_view     (ring_view),
    .owned_view    (owned_view),
    .awaiting_view (awaiting_view),
    .freed_view    (freed_view),
    .unfreed_view  (unfreed_view)
  );

  always #5 clk = ~clk;

  // every field random, so fields an operation ignores still toggle
  function automatic item_t random_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(item_t)-1:0];
  endfunction

  function automatic item_t acquire_word(logic [SEQ_W-1:0] sample);
    item_t w;
    w = random_word();
    w.func = FUNC_ACQUIRE;
    w.freed_sample = sample;
    return w;
  endfunction

  function automatic item_t send_word(logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len);
    item_t w;
    w = random_word();
    w.func = FUNC_SEND;
    w.slot_index = slot;
    w.msg_bytes = len;
    return w;
  endfunction

  function automatic item_t completion_word(logic ok);
    item_t w;
    w = random_word();
    w.func = FUNC_COMPLETION;
    w.completion_ok = ok;
    return w;
  endfunction

  // lengths cluster round zero, the inline limit and the message limit
  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 4) return '0;
    if (sel < 8 && cur_max_inl != 0) return LEN_W'($urandom_range(cur_max_inl, 1));
    if (sel < 9) return LEN_W'(cur_max_inl) + LEN_W'($urandom_range(1));
    if (sel < 15) return LEN_W'($urandom_range(cur_max_msg, 0));
    if (sel < 17) return cur_max_msg;
    if (sel < 19 && cur_max_msg != '1)
      return LEN_W'($urandom_range(24'hFFFFFF, cur_max_msg + 1));
    return LEN_W'($urandom);
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(3, 1);
    if (sel < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // called at a rising edge; returns at the edge that accepts the last word
  task automatic send_words(input item_t words[$], input bit burst);
    int g;
    foreach (words[i]) begin
      g = burst ? 0 : pick_gap();
      if (g > 0) begin
        start <= 1'b0;
        item  <= random_word();
        repeat (g) @(posedge clk);
      end
      item  <= words[i];
      start <= 1'b1;
      do @(posedge clk); while (busy);
    end
  endtask

  // stop sending and wait until every predicted word has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    // margin for the registered path through the core
    repeat (3) @(posedge clk);
  endtask

  // register writes, only ever issued with the core idle
  task automatic apply_setting(logic [BC_W-1:0] bc, logic [LEN_W-1:0] mm,
                               logic [INL_W-1:0] mi, bit write_bc);
    if (write_bc) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_BUFFER_COUNT;
      cfg_data  <= CFG_DATA_W'(bc);
      @(posedge clk);
    end
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAX_MESSAGE;
    cfg_data  <= CFG_DATA_W'(mm);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAX_INLINE;
    cfg_data  <= CFG_DATA_W'(mi);
    @(posedge clk);
    cfg_write   <= 1'b0;
    cur_max_msg  = mm;
    cur_max_inl  = mi;
  endtask

  // one well-formed round of the ring with random content and a little noise:
  // send slots still owned, acquire a run of slots with the right freed words,
  // then send them with completions sprinkled in between
  task automatic run_batch();
    item_t words[$];
    int    n;
    int    p;
    int    m;
    int    slot;
    bit    burst;
    // drop start first so the ring view below includes every accepted word
    start <= 1'b0;
    @(negedge clk);
    n = int'(slots_view);
    p = int'(ring_view);
    for (int k = 0; k < n; k++)
      if (owned_view[k]) words.push_back(send_word(SLOT_W'(k), pick_length()));
    m = $urandom_range(n, 1);
    // one extra acquire wraps onto a slot the application still owns
    if ($urandom_range(9) == 0) m = n + 1;
    for (int j = 0; j < m; j++) begin
      slot = (p + j) % n;
      if (awaiting_view[slot] && $urandom_range(9) == 0)
        words.push_back(acquire_word(unfreed_view[slot]));
      if ($urandom_range(19) == 0) words.push_back(acquire_word($urandom));
      words.push_back(acquire_word(awaiting_view[slot] ? freed_view[slot] : $urandom));
    end
    if (m > n) m = n;
    for (int j = 0; j < m; j++) begin
      slot = (p + j) % n;
      if ($urandom_range(2) == 0) words.push_back(completion_word(1'b1));
      if ($urandom_range(29) == 0) words.push_back(completion_word(1'b0));
      if ($urandom_range(19) == 0) words.push_back(random_word());
      if ($urandom_range(19) == 0) slot = $urandom_range(15);
      words.push_back(send_word(SLOT_W'(slot), pick_length()));
    end
    burst = ($urandom_range(3) == 0);
    @(posedge clk);
    send_words(words, burst);
    phase_words += words.size();
  endtask

  task automatic run_phase(logic [BC_W-1:0] bc, logic [LEN_W-1:0] mm,
                           logic [INL_W-1:0] mi, bit write_bc, int words);
    drain();
    apply_setting(bc, mm, mi, write_bc);
    phase_words = 0;
    while (phase_words < words) run_batch();
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cur_max_msg = MAX_MSG_RESET;
    cur_max_inl = MAX_INL_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words on the reset registers: sixteen slots, 4096 bytes, nothing inline
    plan.push_back(completion_word(1'b1));      // nothing pending
    plan.push_back(completion_word(1'b0));      // completion failed
    plan.push_back(random_word());
    plan[2].func = FUNC_UNUSED;                  // unused func value
    plan.push_back(send_word(4'd0, 24'd10));    // slot not owned
    plan.push_back(acquire_word('1));           // slot 0 granted, not awaiting
    plan.push_back(acquire_word('0));           // slot 1 granted
    plan.push_back(send_word(4'd0, 24'd4097));  // longer than allowed
    plan.push_back(send_word(4'd15, '1));       // not owned, longest length
    plan.push_back(send_word(4'd0, 24'd0));     // header only, signalled
    plan.push_back(send_word(4'd1, 24'd4096));  // largest allowed length
    plan.push_back(send_word(4'd1, 24'd0));     // already sent
    send_words(plan, 1'b0);

    // two slots, small limits, so the ring wraps and the pacing stalls quickly
    drain();
    apply_setting(5'd2, 24'd100, 10'd10, 1'b1);
    plan.delete();
    plan.push_back(acquire_word($urandom));     // slot 0 granted
    plan.push_back(acquire_word($urandom));     // slot 1 granted
    plan.push_back(acquire_word($urandom));     // slot 0 still owned
    plan.push_back(send_word(4'd0, 24'd5));     // inline, signalled
    plan.push_back(send_word(4'd1, 24'd10));    // inline at the limit
    plan.push_back(send_word(4'd2, 24'd1));     // slot beyond the ring
    plan.push_back(acquire_word(32'd0));        // still the not-freed number
    plan.push_back(acquire_word(32'hDEADBEEF)); // freed mismatch
    plan.push_back(acquire_word(32'd1));        // freed, granted
    plan.push_back(send_word(4'd0, 24'd11));    // blocked, completion needed
    plan.push_back(completion_word(1'b0));      // failed completion changes nothing
    plan.push_back(completion_word(1'b1));
    plan.push_back(send_word(4'd0, 24'd11));    // retried: pacing restarts
    plan.push_back(send_word(4'd0, 24'd0));     // no longer owned
    send_words(plan, 1'b0);

    // random part, one register setting per phase, extremes included;
    // each phase starts only once every result of the last has come back
    run_phase(5'd16, 24'd4096, 10'd0, 1'b1, 100);
    run_phase(5'd1, 24'd0, 10'd0, 1'b1, 80);
    run_phase(5'd1, 24'hFFFFFF, 10'd1023, 1'b0, 60);   // limits change, ring kept
    run_phase(5'd16, 24'hFFFFFF, 10'd1023, 1'b1, 120);
    run_phase(5'd0, 24'd1023, 10'd1023, 1'b1, 60);     // zero slots acts as one
    run_phase(5'd31, 24'd5000, 10'd300, 1'b1, 100);    // above the maximum acts as sixteen
    run_phase(5'd3, 24'd2000, 10'd50, 1'b1, 100);
    run_phase(BC_W'($urandom_range(16, 1)), LEN_W'($urandom), INL_W'($urandom), 1'b1, 100);
    run_phase(5'd8, 24'd600, 10'd599, 1'b0, 80);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
